FILE: sv/lmfs_pkg.sv
// Shared types, constants and helper functions for the LED matrix frame shifter.
`default_nettype none

package lmfs_pkg;

  localparam int PanelCount      = 5;
  localparam int ColumnsPerPanel = 40;
  localparam int TotalColumns    = PanelCount * ColumnsPerPanel;
  localparam int AddrW           = $clog2(TotalColumns);
  localparam int BitsPerLane     = 8;
  localparam int WordW           = 16;

  localparam logic [2:0] ACT_CLEAR     = 3'd0;
  localparam logic [2:0] ACT_SET_PIXEL = 3'd1;
  localparam logic [2:0] ACT_WRITE_COL = 3'd2;
  localparam logic [2:0] ACT_WRITE_DBL = 3'd3;
  localparam logic [2:0] ACT_READ_PIX  = 3'd4;
  localparam logic [2:0] ACT_SHIFT     = 3'd5;

  localparam logic [7:0] LastColumn = 8'(TotalColumns - 1);
  localparam logic [2:0] LastBit    = 3'(BitsPerLane - 1);

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  column;
    logic [3:0]  row;
    logic [15:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic pixel_bit;
    logic shift_strobe;
    logic data_low_bit;
    logic data_high_bit;
    logic latch_pulse;
    logic output_enable;
    logic column_error;
  } out_item_t;

  // Each bit of the byte lights a pair of adjacent rows.
  function automatic logic [WordW-1:0] doubled_word(input logic [7:0] byte_val);
    logic [WordW-1:0] w;
    w = '0;
    for (int i = 0; i < BitsPerLane; i++) begin
      w[2*i]   = byte_val[i];
      w[2*i+1] = byte_val[i];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lmfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lmfs_ram #(
  parameter int Width = 16,
  parameter int Depth = 200,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/led_matrix_frame_shifter_top.sv
// Top level of the LED matrix frame shifter: frame store, scan position and result register.
// A beat waits in s1 while the store is read; its result is then registered in out_item_q.
// Throughput: one beat per cycle for every action, clear included, unless the output stalls;
// the store is read on accept and written back when s1 fires; back-to-back accesses bypass.
// Reset: per-entry valid flops make the whole store read as zero at once; the scan position
// goes to column 0, bit 0, and screen_enable to 1. No clearing pass is needed.
`default_nettype none

module led_matrix_frame_shifter_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lmfs_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lmfs_pkg::out_item_t     out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic               cfg_data_i
);

  logic                          screen_enable_q;
  logic                          s1_valid_q, s1_valid_d;
  lmfs_pkg::in_item_t            s1_item_q;
  logic                          rd_vld_q, rd_vld_d;
  logic                          rd_hit_q, rd_hit_d;
  logic [lmfs_pkg::WordW-1:0]    rd_byp_q;
  logic [lmfs_pkg::TotalColumns-1:0] valid_q;
  logic [7:0]                    scan_col_q, scan_col_d;
  logic [2:0]                    scan_bit_q, scan_bit_d;
  logic                          out_valid_q;
  lmfs_pkg::out_item_t           out_item_q, res_d;

  logic                          accept, s1_fire, col_ok, clear_all, wr_en;
  logic [lmfs_pkg::WordW-1:0]    word, wr_data, rdata, row_mask;
  logic [lmfs_pkg::AddrW-1:0]    wr_addr, rd_addr;
  logic [7:0]                    rd_col;
  logic                          rd_in_range;

  assign cfg_ready_o = 1'b1;
  assign s1_fire     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_fire;
  assign accept      = in_valid_i && in_ready_o;

  assign word = rd_hit_q ? rd_byp_q : (rd_vld_q ? rdata : '0);
  assign col_ok   = s1_item_q.column < 8'(lmfs_pkg::TotalColumns);
  assign row_mask = {{(lmfs_pkg::WordW-1){1'b0}}, 1'b1} << s1_item_q.row;
  assign wr_addr  = s1_item_q.column[lmfs_pkg::AddrW-1:0];

  always_comb begin
    res_d               = '0;
    res_d.output_enable = screen_enable_q;
    wr_en               = 1'b0;
    wr_data             = word;
    clear_all           = 1'b0;
    scan_col_d          = scan_col_q;
    scan_bit_d          = scan_bit_q;
    case (s1_item_q.action)
      lmfs_pkg::ACT_CLEAR: begin
        clear_all = s1_fire;
      end
      lmfs_pkg::ACT_SET_PIXEL, lmfs_pkg::ACT_WRITE_COL,
      lmfs_pkg::ACT_WRITE_DBL, lmfs_pkg::ACT_READ_PIX: begin
        res_d.column_error = !col_ok;
        if (col_ok) begin
          case (s1_item_q.action)
            lmfs_pkg::ACT_SET_PIXEL: begin
              wr_en   = s1_fire;
              wr_data = (s1_item_q.write_value != '0) ? (word | row_mask)
                                                      : (word & ~row_mask);
            end
            lmfs_pkg::ACT_WRITE_COL: begin
              wr_en   = s1_fire;
              wr_data = s1_item_q.write_value;
            end
            lmfs_pkg::ACT_WRITE_DBL: begin
              wr_en   = s1_fire;
              wr_data = lmfs_pkg::doubled_word(s1_item_q.write_value[7:0]);
            end
            default: begin
              res_d.pixel_bit = word[s1_item_q.row];
            end
          endcase
        end
      end
      lmfs_pkg::ACT_SHIFT: begin
        res_d.shift_strobe  = 1'b1;
        res_d.data_low_bit  = word[{1'b0, scan_bit_q}];
        res_d.data_high_bit = word[{1'b1, scan_bit_q}];
        if (scan_bit_q == lmfs_pkg::LastBit) begin
          scan_bit_d = '0;
          if (scan_col_q >= lmfs_pkg::LastColumn) begin
            scan_col_d        = '0;
            res_d.latch_pulse = 1'b1;
          end else begin
            scan_col_d = scan_col_q + 8'd1;
          end
        end else begin
          scan_bit_d = scan_bit_q + 3'd1;
        end
        if (!s1_fire) begin
          scan_col_d = scan_col_q;
          scan_bit_d = scan_bit_q;
        end
      end
      default: begin
      end
    endcase
  end

  // A shift tick reads the column that the scan stands on after the beat now finishing.
  assign rd_col      = (in_item_i.action == lmfs_pkg::ACT_SHIFT) ? scan_col_d
                                                                 : in_item_i.column;
  assign rd_in_range = rd_col < 8'(lmfs_pkg::TotalColumns);
  assign rd_addr     = rd_col[lmfs_pkg::AddrW-1:0];
  assign rd_hit_d    = wr_en && (wr_addr == rd_addr) && rd_in_range;
  assign rd_vld_d    = rd_in_range && !clear_all && valid_q[rd_addr];

  lmfs_ram #(
    .Width(lmfs_pkg::WordW),
    .Depth(lmfs_pkg::TotalColumns)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_enable_q <= 1'b1;
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      valid_q         <= '0;
      scan_col_q      <= '0;
      scan_bit_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        screen_enable_q <= cfg_data_i;
      end
      s1_valid_q <= s1_valid_d;
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear_all) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      scan_col_q <= scan_col_d;
      scan_bit_q <= scan_bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
      rd_vld_q  <= rd_vld_d;
      rd_hit_q  <= rd_hit_d;
      rd_byp_q  <= wr_data;
    end
    if (s1_fire) begin
      out_item_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_col_q < 8'(lmfs_pkg::TotalColumns))
    else $error("Scan column left the frame.");

  a_latch_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res_d.latch_pulse) |=> (scan_col_q == '0 && scan_bit_q == '0))
    else $error("Scan did not wrap after the latch pulse.");

  a_latch_on_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.latch_pulse) |-> out_item_o.shift_strobe)
    else $error("Latch pulse without a shift beat.");

  a_error_not_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.column_error && out_item_o.shift_strobe))
    else $error("Column error raised on a shift beat.");

endmodule

`default_nettype wire
